// ===== hw/rtl/cdbp_pkg.sv =====
// Shared types and constants for the client data block parser.
package cdbp_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_CORE_TYPE     = 2'd0;
   localparam logic [1:0] CSR_SECURITY_TYPE = 2'd1;
   localparam logic [1:0] CSR_NETWORK_TYPE  = 2'd2;

   // Reset values of the block type codes
   localparam logic [15:0] CORE_TYPE_RESET     = 16'hC001;
   localparam logic [15:0] SECURITY_TYPE_RESET = 16'hC002;
   localparam logic [15:0] NETWORK_TYPE_RESET  = 16'hC003;

   // Header is 4 bytes; minimum total lengths for known blocks
   localparam logic [15:0] HDR_BYTES       = 16'd4;
   localparam logic [15:0] CORE_MIN_LEN    = 16'd12;
   localparam logic [15:0] NET_MIN_LEN     = 16'd8;
   // Long core block: protocols word at payload offset 208..211
   localparam logic [15:0] CORE_LONG_PLEN  = 16'd212;
   localparam logic [13:0] PROTO_WORD_IDX  = 14'd52;

   localparam logic [2:0] SEEN_ALL = 3'b111;

   typedef enum logic [0:0] {
      PH_HEADER  = 1'b0,
      PH_PAYLOAD = 1'b1
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_CORE  = 2'd1,
      KIND_SEC   = 2'd2,
      KIND_NET   = 2'd3
   } kind_type;

   // Type codes from the configuration registers
   typedef struct packed {
      logic [15:0] core;
      logic [15:0] security;
      logic [15:0] network;
   } type_codes_type;

   // One parse result
   typedef struct packed {
      logic        status;
      logic [31:0] version;
      logic [15:0] disp_width;
      logic [15:0] disp_height;
      logic [31:0] proto_mask;
      logic [15:0] num_channels;
   } cdbp_result_type;

endpackage

// ===== hw/rtl/cdbp_req_if.sv =====
// Request channel: one message byte per transfer.
interface cdbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

// ===== hw/rtl/cdbp_rsp_if.sv =====
// Response channel: one parse result per message.
interface cdbp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] version;
   logic [15:0] disp_width;
   logic [15:0] disp_height;
   logic [31:0] proto_mask;
   logic [15:0] num_channels;

   modport source (output valid, output status, output version, output disp_width,
                   output disp_height, output proto_mask,
                   output num_channels, input ready);
   modport sink   (input valid, input status, input version, input disp_width,
                   input disp_height, input proto_mask,
                   input num_channels, output ready);
endinterface

// ===== hw/rtl/client_data_block_parser.sv =====
// Top level of the client data block parser: CSRs, parse engine, result buffer.
//
//   channel   dir   handshake        payload
//   req_if    in    valid/ready      data_byte[7:0], is_last
//   rsp_if    out   valid/ready      status, version[31:0], disp_width[15:0],
//                                    disp_height[15:0], proto_mask[31:0],
//                                    num_channels[15:0]
//   csr_*     in    csr_wr_en        csr_index[1:0], csr_wr_data[15:0]
//
// One request byte per cycle while req ready is high; the parse state updates at the
// edge that accepts it. A message result is presented the cycle after its last byte
// when the output register is free or drains that cycle; otherwise it waits in the
// skid slot until it drains. Two result slots (output register plus skid); req ready
// drops only when both are full. Synchronous active-high reset returns the type codes
// to their defaults and clears all parse state; no clearing pass is needed.
module client_data_block_parser
   import cdbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   cdbp_req_if.sink      req_if,
   cdbp_rsp_if.source    rsp_if,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wr_data
);

   type_codes_type  codes_ff;
   cdbp_result_type res;
   cdbp_result_type out_ff, skid_ff;
   logic            out_vld_ff, skid_vld_ff;
   logic            res_valid;
   logic            take;
   logic            drain;

   // Type code registers
   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.core     <= CORE_TYPE_RESET;
         codes_ff.security <= SECURITY_TYPE_RESET;
         codes_ff.network  <= NETWORK_TYPE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CORE_TYPE:     codes_ff.core     <= csr_wr_data;
            CSR_SECURITY_TYPE: codes_ff.security <= csr_wr_data;
            CSR_NETWORK_TYPE:  codes_ff.network  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign req_if.ready = !skid_vld_ff;
   assign take         = req_if.valid && req_if.ready;
   assign drain        = out_vld_ff && rsp_if.ready;

   cdbp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_if.data_byte),
      .is_last   (req_if.is_last),
      .codes     (codes_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result buffer: output register with one skid slot behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (drain) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (!out_vld_ff || drain) begin
            out_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (drain) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (drain) out_ff <= skid_ff;
      end else if (res_valid) begin
         if (!out_vld_ff || drain) out_ff <= res;
         else                      skid_ff <= res;
      end
   end

   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.status       = out_ff.status;
   assign rsp_if.version      = out_ff.version;
   assign rsp_if.disp_width   = out_ff.disp_width;
   assign rsp_if.disp_height  = out_ff.disp_height;
   assign rsp_if.proto_mask   = out_ff.proto_mask;
   assign rsp_if.num_channels = out_ff.num_channels;

endmodule

// ===== hw/rtl/cdbp_engine.sv =====
// Byte-wise block chain walker: header/payload tracking and field capture.
module cdbp_engine
   import cdbp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [7:0]      data_byte,
   input  logic            is_last,
   input  type_codes_type  codes,
   output logic            res_valid,
   output cdbp_result_type res
);

   phase_type   phase_ff,  phase_in;
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [15:0] kind_ff,   kind_in;
   logic [15:0] len_ff,    len_in;
   logic [15:0] off_ff,    off_in;
   logic [31:0] version_ff, version_in;
   logic [15:0] width_ff,  width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] proto_ff,  proto_in;
   logic [15:0] chan_ff,   chan_in;
   logic [2:0]  seen_ff,   seen_in;
   logic        err_ff,    err_in;

   kind_type    cls;
   logic [15:0] full_len;
   logic [15:0] plen;
   logic [15:0] off_next;
   logic        msg_ok;

   // Classify the current block type; core beats security beats network
   always_comb begin
      if (kind_ff == codes.core)          cls = KIND_CORE;
      else if (kind_ff == codes.security) cls = KIND_SEC;
      else if (kind_ff == codes.network)  cls = KIND_NET;
      else                                cls = KIND_OTHER;
   end

   assign full_len = {data_byte, len_ff[7:0]};
   assign plen     = len_ff - HDR_BYTES;
   assign off_next = off_ff + 16'd1;

   // Next state for one byte
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      kind_in    = kind_ff;
      len_in     = len_ff;
      off_in     = off_ff;
      version_in = version_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      proto_in   = proto_ff;
      chan_in    = chan_ff;
      seen_in    = seen_ff;
      err_in     = err_ff;

      if (take && !err_ff) begin
         if (phase_ff == PH_HEADER) begin
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
            case (hdr_cnt_ff)
               2'd0: kind_in = {8'h00, data_byte};
               2'd1: kind_in = {data_byte, kind_ff[7:0]};
               2'd2: len_in  = {8'h00, data_byte};
               default: begin
                  len_in = full_len;
                  if (full_len < HDR_BYTES) begin
                     err_in = 1'b1;
                  end else if ((cls == KIND_CORE || cls == KIND_SEC) &&
                               full_len < CORE_MIN_LEN) begin
                     err_in = 1'b1;
                  end else if (cls == KIND_NET && full_len < NET_MIN_LEN) begin
                     err_in = 1'b1;
                  end else begin
                     if (cls == KIND_CORE) seen_in[0] = 1'b1;
                     if (cls == KIND_SEC)  seen_in[1] = 1'b1;
                     if (cls == KIND_NET)  seen_in[2] = 1'b1;
                     off_in   = '0;
                     phase_in = (full_len != HDR_BYTES) ? PH_PAYLOAD : PH_HEADER;
                  end
               end
            endcase
         end else begin
            // Payload byte: first byte of a field loads it, later bytes merge in
            if (cls == KIND_CORE) begin
               if (off_ff[15:2] == 14'd0) begin
                  case (off_ff[1:0])
                     2'd0: version_in = {24'h00_0000, data_byte};
                     2'd1: version_in[15:8]  = version_ff[15:8] | data_byte;
                     2'd2: version_in[23:16] = version_ff[23:16] | data_byte;
                     default: version_in[31:24] = version_ff[31:24] | data_byte;
                  endcase
               end else if (off_ff[15:2] == 14'd1) begin
                  case (off_ff[1:0])
                     2'd0: width_in = {8'h00, data_byte};
                     2'd1: width_in[15:8] = width_ff[15:8] | data_byte;
                     2'd2: height_in = {8'h00, data_byte};
                     default: height_in[15:8] = height_ff[15:8] | data_byte;
                  endcase
               end else if (plen >= CORE_LONG_PLEN && off_ff[15:2] == PROTO_WORD_IDX) begin
                  case (off_ff[1:0])
                     2'd0: proto_in = {24'h00_0000, data_byte};
                     2'd1: proto_in[15:8]  = proto_ff[15:8] | data_byte;
                     2'd2: proto_in[23:16] = proto_ff[23:16] | data_byte;
                     default: proto_in[31:24] = proto_ff[31:24] | data_byte;
                  endcase
               end
            end else if (cls == KIND_NET) begin
               if (off_ff == 16'd0) chan_in = {8'h00, data_byte};
               if (off_ff == 16'd1) chan_in[15:8] = chan_ff[15:8] | data_byte;
            end
            off_in = off_next;
            if (off_next >= plen) begin
               phase_in = PH_HEADER;
               off_in   = '0;
            end
         end
      end

      // Message end: build result from the updated state, then start over
      msg_ok = !err_in && phase_in == PH_HEADER && hdr_cnt_in == 2'd0 &&
               seen_in == SEEN_ALL;
      res.status       = !msg_ok;
      res.version      = msg_ok ? version_in : '0;
      res.disp_width   = msg_ok ? width_in   : '0;
      res.disp_height  = msg_ok ? height_in  : '0;
      res.proto_mask   = msg_ok ? proto_in   : '0;
      res.num_channels = msg_ok ? chan_in    : '0;
      res_valid        = take && is_last;

      if (take && is_last) begin
         phase_in   = PH_HEADER;
         hdr_cnt_in = '0;
         kind_in    = '0;
         len_in     = '0;
         off_in     = '0;
         version_in = '0;
         width_in   = '0;
         height_in  = '0;
         proto_in   = '0;
         chan_in    = '0;
         seen_in    = '0;
         err_in     = 1'b0;
      end
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         kind_ff    <= '0;
         len_ff     <= '0;
         off_ff     <= '0;
         version_ff <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         proto_ff   <= '0;
         chan_ff    <= '0;
         seen_ff    <= '0;
         err_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         kind_ff    <= kind_in;
         len_ff     <= len_in;
         off_ff     <= off_in;
         version_ff <= version_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         proto_ff   <= proto_in;
         chan_ff    <= chan_in;
         seen_ff    <= seen_in;
         err_ff     <= err_in;
      end
   end

endmodule

// ===== sim/client_data_block_parser_tb.sv =====
// Self-checking bench for client_data_block_parser: byte chains in, parse results checked.
module client_data_block_parser_tb
   import cdbp_pkg::*;
();

   localparam int unsigned STALL_LIMIT     = 2000;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned HOLDOFF_CYCLES  = 150;
   localparam logic [1:0]  CSR_SPARE_INDEX = 2'd3;
   localparam logic [15:0] FOREIGN_TYPE    = 16'h1111;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wr_data;

   cdbp_req_if req_if ();
   cdbp_rsp_if rsp_if ();

   client_data_block_parser DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Bench control
   int unsigned     req_idle_pct;
   int unsigned     rsp_idle_pct;
   int unsigned     rsp_holdoff;
   int unsigned     quiet_cycles = 0;
   int unsigned     fail_count = 0;
   logic [7:0]      msg_bytes[$];
   cdbp_result_type message_results[$];

   // Parser shadow: type codes and per-message state
   logic [15:0] code_core, code_sec, code_net;
   phase_type   pr_phase;
   logic [1:0]  pr_hdr_count;
   logic [15:0] pr_kind, pr_len, pr_offset;
   logic [31:0] pr_version, pr_protocols;
   logic [15:0] pr_width, pr_height, pr_channels;
   logic [2:0]  pr_seen;
   logic        pr_error;

   task note_failure(input string what);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         note_failure($sformatf("%s: got %0h, expected %0h", name, got, want));
   endtask

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] rand8();
      return 8'($urandom);
   endfunction

   function automatic kind_type block_class(input logic [15:0] kind);
      if (kind == code_core) return KIND_CORE;
      if (kind == code_sec) return KIND_SEC;
      if (kind == code_net) return KIND_NET;
      return KIND_OTHER;
   endfunction

   function void clear_parse_state();
      pr_phase     = PH_HEADER;
      pr_hdr_count = '0;
      pr_kind      = '0;
      pr_len       = '0;
      pr_offset    = '0;
      pr_version   = '0;
      pr_width     = '0;
      pr_height    = '0;
      pr_protocols = '0;
      pr_channels  = '0;
      pr_seen      = '0;
      pr_error     = 1'b0;
   endfunction

   // Advance the shadow parser by one accepted byte; queue a result on the last one
   task automatic parse_byte(input logic [7:0] b, input logic last);
      kind_type        cls;
      logic [15:0]     plen;
      logic            ok;
      cdbp_result_type res;
      if (!pr_error) begin
         if (pr_phase == PH_HEADER) begin
            case (pr_hdr_count)
               2'd0: pr_kind = {8'h00, b};
               2'd1: pr_kind[15:8] = b;
               2'd2: pr_len = {8'h00, b};
               default: begin
                  pr_len[15:8] = b;
                  cls = block_class(pr_kind);
                  if (pr_len < HDR_BYTES) begin
                     pr_error = 1'b1;
                  end else if ((cls == KIND_CORE || cls == KIND_SEC) && pr_len < CORE_MIN_LEN) begin
                     pr_error = 1'b1;
                  end else if (cls == KIND_NET && pr_len < NET_MIN_LEN) begin
                     pr_error = 1'b1;
                  end else begin
                     case (cls)
                        KIND_CORE: pr_seen[0] = 1'b1;
                        KIND_SEC:  pr_seen[1] = 1'b1;
                        KIND_NET:  pr_seen[2] = 1'b1;
                        default: ;
                     endcase
                     pr_offset = '0;
                     pr_phase  = (pr_len > HDR_BYTES) ? PH_PAYLOAD : PH_HEADER;
                  end
               end
            endcase
            pr_hdr_count = pr_hdr_count + 2'd1;
         end else begin
            cls  = block_class(pr_kind);
            plen = pr_len - HDR_BYTES;
            if (cls == KIND_CORE) begin
               if (pr_offset[15:2] == '0) begin
                  if (pr_offset == 16'd0) pr_version = {24'h0, b};
                  else pr_version[8*pr_offset[1:0] +: 8] =
                     pr_version[8*pr_offset[1:0] +: 8] | b;
               end else if (pr_offset == 16'd4) begin
                  pr_width = {8'h00, b};
               end else if (pr_offset == 16'd5) begin
                  pr_width[15:8] = pr_width[15:8] | b;
               end else if (pr_offset == 16'd6) begin
                  pr_height = {8'h00, b};
               end else if (pr_offset == 16'd7) begin
                  pr_height[15:8] = pr_height[15:8] | b;
               end else if (plen >= CORE_LONG_PLEN && pr_offset[15:2] == PROTO_WORD_IDX) begin
                  if (pr_offset[1:0] == 2'd0) pr_protocols = {24'h0, b};
                  else pr_protocols[8*pr_offset[1:0] +: 8] =
                     pr_protocols[8*pr_offset[1:0] +: 8] | b;
               end
            end else if (cls == KIND_NET) begin
               if (pr_offset == 16'd0) pr_channels = {8'h00, b};
               else if (pr_offset == 16'd1) pr_channels[15:8] = pr_channels[15:8] | b;
            end
            pr_offset = pr_offset + 16'd1;
            if (pr_offset >= plen) begin
               pr_phase  = PH_HEADER;
               pr_offset = '0;
            end
         end
      end
      if (last) begin
         ok = !pr_error && pr_phase == PH_HEADER && pr_hdr_count == 2'd0 && pr_seen == SEEN_ALL;
         res = '0;
         res.status = ~ok;
         if (ok) begin
            res.version      = pr_version;
            res.disp_width   = pr_width;
            res.disp_height  = pr_height;
            res.proto_mask   = pr_protocols;
            res.num_channels = pr_channels;
         end
         message_results.push_back(res);
         clear_parse_state();
      end
   endtask

   // Message builders, all appending to msg_bytes
   function void put_header(input logic [15:0] kind, input logic [15:0] len);
      msg_bytes.push_back(kind[7:0]);
      msg_bytes.push_back(kind[15:8]);
      msg_bytes.push_back(len[7:0]);
      msg_bytes.push_back(len[15:8]);
   endfunction

   function void put_block(input logic [15:0] kind, input int unsigned plen);
      put_header(kind, 16'(plen) + HDR_BYTES);
      repeat (plen) msg_bytes.push_back(rand8());
   endfunction

   function void put_core(input int unsigned plen, input logic [31:0] ver,
                          input logic [15:0] wid, input logic [15:0] hgt,
                          input logic [31:0] proto);
      logic [7:0] b;
      put_header(code_core, 16'(plen) + HDR_BYTES);
      for (int unsigned off = 0; off < plen; off++) begin
         if (off < 4) b = ver[8*off +: 8];
         else if (off < 6) b = wid[8*(off-4) +: 8];
         else if (off < 8) b = hgt[8*(off-6) +: 8];
         else if (off >= 208 && off < 212) b = proto[8*(off-208) +: 8];
         else b = rand8();
         msg_bytes.push_back(b);
      end
   endfunction

   function void put_net(input int unsigned plen, input logic [15:0] chans);
      put_header(code_net, 16'(plen) + HDR_BYTES);
      msg_bytes.push_back(chans[7:0]);
      msg_bytes.push_back(chans[15:8]);
      repeat (plen - 2) msg_bytes.push_back(rand8());
   endfunction

   // Core, security and network blocks in random order, plus unknown ones; drop_one omits one
   function void build_valid_chain(input bit drop_one);
      kind_type   kinds[$];
      kind_type   tmp;
      int unsigned j;
      kinds = '{KIND_CORE, KIND_SEC, KIND_NET};
      if (drop_one) kinds.delete($urandom_range(2));
      repeat ($urandom_range(2)) kinds.push_back(KIND_OTHER);
      if ($urandom_range(3) == 0) kinds.push_back($urandom_range(1) ? KIND_CORE : KIND_NET);
      for (int i = kinds.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = kinds[i];
         kinds[i] = kinds[j];
         kinds[j] = tmp;
      end
      foreach (kinds[i]) begin
         case (kinds[i])
            KIND_CORE: put_core($urandom_range(8, 12), $urandom, rand16(), rand16(),
                                $urandom);
            KIND_SEC:  put_block(code_sec, $urandom_range(8, 12));
            KIND_NET:  put_net($urandom_range(4, 8), rand16());
            default:   put_block(rand16(), $urandom_range(0, 6));
         endcase
      end
   endfunction

   // Offer one request byte; tasks start and end just after a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid     <= 1'b0;
         req_if.data_byte <= rand8();
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.is_last   <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      parse_byte(b, last);
      @(negedge clock);
   endtask

   task send_message();
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      msg_bytes.delete();
   endtask

   // Stop sending and let every outstanding result come back
   task wait_results_drained();
      req_if.valid <= 1'b0;
      while (message_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task set_type_codes(input logic [15:0] core, input logic [15:0] sec, input logic [15:0] net);
      wait_results_drained();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_CORE_TYPE;
      csr_wr_data <= core;
      @(negedge clock);
      csr_index   <= CSR_SECURITY_TYPE;
      csr_wr_data <= sec;
      @(negedge clock);
      csr_index   <= CSR_NETWORK_TYPE;
      csr_wr_data <= net;
      @(negedge clock);
      // unused index must be ignored
      csr_index   <= CSR_SPARE_INDEX;
      csr_wr_data <= rand16();
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      code_core = core;
      code_sec  = sec;
      code_net  = net;
   endtask

   // Complete chains under the reset type codes, field extremes, zero-length unknown
   task test_default_codes_chain();
      put_core(8, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h0);
      put_block(code_sec, 8);
      put_net(4, 16'hFFFF);
      send_message();
      put_net(4, 16'h0000);
      put_block(16'h0000, 0);
      put_block(code_sec, 8);
      put_core(8, 32'h0, 16'h0, 16'h0, 32'h0);
      send_message();
   endtask

   // Protocols word captured from a core payload of exactly 212 bytes
   task test_long_core_block();
      put_core(212, $urandom, rand16(), rand16(), 32'hFFFF_FFFF);
      put_block(code_sec, 8);
      put_net(4, rand16());
      send_message();
   endtask

   // Every protocol error kind, each as its own message
   task test_protocol_errors();
      // header cut after one and after three bytes
      msg_bytes.push_back(8'h01);
      send_message();
      put_header(code_core, 16'd12);
      void'(msg_bytes.pop_back());
      send_message();
      // lengths below the header size; bytes after the error are ignored
      put_header(code_core, 16'd0);
      send_message();
      put_header(FOREIGN_TYPE, 16'd3);
      repeat (6) msg_bytes.push_back(rand8());
      send_message();
      // known blocks too short
      put_block(code_core, 7);
      send_message();
      put_block(code_sec, 7);
      send_message();
      put_block(code_net, 3);
      send_message();
      // payload cut by the end of the message
      put_header(FOREIGN_TYPE, 16'hFFFF);
      put_block(code_sec, 6);
      send_message();
      // clean chain missing the network block
      put_core(8, $urandom, rand16(), rand16(), $urandom);
      put_block(code_sec, 8);
      send_message();
      // clean chain followed by a partial header
      build_valid_chain(1'b0);
      msg_bytes.push_back(rand8());
      msg_bytes.push_back(rand8());
      send_message();
   endtask

   // Equal type codes: core beats security, security beats network
   task test_overlapping_codes();
      set_type_codes(16'h0000, 16'h0000, 16'h0000);
      put_core(8, $urandom, rand16(), rand16(), $urandom);
      put_block(16'h0000, 8);
      put_block(16'h0000, 10);
      send_message();
      set_type_codes(16'hFFFF, 16'hFFFF, 16'h0000);
      put_core(8, $urandom, rand16(), rand16(), $urandom);
      put_net(4, rand16());
      put_block(16'hFFFF, 8);
      send_message();
      set_type_codes(16'h1234, 16'h5678, 16'h5678);
      put_core(8, $urandom, rand16(), rand16(), $urandom);
      put_net(4, rand16());
      send_message();
      put_core(8, $urandom, rand16(), rand16(), $urandom);
      put_block(code_net, 8);
      send_message();
      set_type_codes(16'h0000, 16'hFFFF, 16'h0001);
      build_valid_chain(1'b0);
      send_message();
   endtask

   // Hold the result side off so both result slots fill and the request side stalls
   task test_result_backpressure();
      wait_results_drained();
      rsp_holdoff = HOLDOFF_CYCLES;
      repeat (20) begin
         msg_bytes.push_back(rand8());
         send_message();
      end
      build_valid_chain(1'b0);
      send_message();
      wait_results_drained();
   endtask

   // Mostly well-formed chains with random content, the rest broken or noise
   task run_random_phase(input int unsigned req_pct, input int unsigned rsp_pct);
      int unsigned sent_bytes;
      int unsigned sent_msgs;
      int unsigned cut;
      sent_bytes   = 0;
      sent_msgs    = 0;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      while (sent_bytes < 40 || sent_msgs < 2) begin
         case ($urandom_range(9))
            6: begin
               // truncated chain
               build_valid_chain(1'b0);
               cut = $urandom_range(1, msg_bytes.size() - 1);
               while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
            end
            7: begin
               // length field below the core block minimum
               put_header($urandom_range(1) ? code_core : rand16(),
                          16'($urandom_range(0, 11)));
               repeat ($urandom_range(8)) msg_bytes.push_back(rand8());
            end
            8: repeat ($urandom_range(1, 24)) msg_bytes.push_back(rand8());
            9: begin
               // corrupted byte, sometimes with a kind missing as well
               build_valid_chain($urandom_range(1));
               msg_bytes[$urandom_range(msg_bytes.size() - 1)] = rand8();
            end
            default: build_valid_chain(1'b0);
         endcase
         sent_bytes += msg_bytes.size();
         sent_msgs++;
         send_message();
      end
   endtask

   // Result side: random stalls, plus a counted hold-off on request
   initial begin : result_receiver
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_holdoff--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Compare each accepted result with the oldest one due
   always @(posedge clock) begin : result_check
      cdbp_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (message_results.size() == 0) begin
            note_failure("result with no message pending");
         end else begin
            want = message_results.pop_front();
            check_field("status", 32'(rsp_if.status), 32'(want.status));
            check_field("version", rsp_if.version, want.version);
            check_field("disp_width", 32'(rsp_if.disp_width), 32'(want.disp_width));
            check_field("disp_height", 32'(rsp_if.disp_height), 32'(want.disp_height));
            check_field("proto_mask", rsp_if.proto_mask, want.proto_mask);
            check_field("num_channels", 32'(rsp_if.num_channels),
                        32'(want.num_channels));
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.is_last   = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_CORE_TYPE;
      csr_wr_data      = '0;
      req_idle_pct     = 37;
      rsp_idle_pct     = 45;
      rsp_holdoff      = 0;
      code_core        = CORE_TYPE_RESET;
      code_sec         = SECURITY_TYPE_RESET;
      code_net         = NETWORK_TYPE_RESET;
      clear_parse_state();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_codes_chain();
      test_long_core_block();
      test_protocol_errors();
      test_overlapping_codes();

      set_type_codes(CORE_TYPE_RESET, SECURITY_TYPE_RESET, NETWORK_TYPE_RESET);
      run_random_phase(37, 45);
      set_type_codes(rand16(), rand16(), rand16());
      run_random_phase(45, 37);
      set_type_codes(16'hFFFF, 16'h0000, 16'h8000);
      run_random_phase(0, 0);
      test_result_backpressure();

      wait_results_drained();
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
